[design/hamming_12_8_codec_defines.svh]
// assertion macros shared by the codec checker
`ifndef HAMMING_12_8_CODEC_DEFINES_SVH
`define HAMMING_12_8_CODEC_DEFINES_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define HMC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define HMC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[design/hmc_pkg.sv]
// types, constants and bit-placement functions of the hamming 12/8 codec
`timescale 1ns / 1ps
`default_nettype none

package hmc_pkg;

  localparam int CwW    = 13;
  localparam int ByteW  = 8;
  localparam int SynW   = 4;
  localparam int CwPosns = 12;

  localparam int InDataW  = 24;
  localparam int OutDataW = 32;
  localparam int OutUserW = 2;

  typedef enum logic {
    ACT_ENCODE = 1'b0,
    ACT_DECODE = 1'b1
  } action_e;

  // codeword positions of data bits 0..7
  localparam logic [SynW-1:0] DataPos [ByteW] = '{
    4'd3, 4'd5, 4'd6, 4'd7, 4'd9, 4'd10, 4'd11, 4'd12
  };

  typedef struct packed {
    logic [CwW-1:0]   codeword_out;
    logic [ByteW-1:0] decoded_byte;
    logic [SynW-1:0]  syndrome;
    logic             was_corrected;
    logic             is_valid;
  } result_t;

  // xor of the indices of every set position 1..12
  function automatic logic [SynW-1:0] syndrome_of(input logic [CwW-1:0] cw);
    logic [SynW-1:0] s;
    s = '0;
    for (int p = 1; p <= CwPosns; p++) begin
      if (cw[p]) s = s ^ SynW'(p);
    end
    return s;
  endfunction

  function automatic logic [ByteW-1:0] extract_byte(input logic [CwW-1:0] cw);
    logic [ByteW-1:0] b;
    b = '0;
    for (int i = 0; i < ByteW; i++) begin
      b[i] = cw[DataPos[i]];
    end
    return b;
  endfunction

  function automatic logic [CwW-1:0] place_byte(input logic [ByteW-1:0] b);
    logic [CwW-1:0] cw;
    cw = '0;
    for (int i = 0; i < ByteW; i++) begin
      cw[DataPos[i]] = b[i];
    end
    return cw;
  endfunction

endpackage

`default_nettype wire

[design/hamming_12_8_codec.sv]
// hamming 12/8 encoder and single-error-correcting decoder, 13-bit codeword
//
// channel | dir | tdata fields (lsb first)                                  | tuser
// s_axis  | in  | data_byte[7:0], received_codeword[20:8], zero pad to 24   | action
// m_axis  | out | codeword_out[12:0], decoded_byte[20:13], syndrome[24:21]  | was_corrected,
//         |     | zero pad to 32                                            | is_valid
//
// one beat in and one beat out per cycle while m_axis is not stalled; a beat passes the
// input register, then xor trees into the result register
// stage one loads while a result waits if it is empty, so a new beat is still taken
// a stall on m_axis back-fills stage by stage; s_axis_tready drops only when both
// stages are full and the result is not taken
// rst_ni clears the stage valid flags only; payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none

module hamming_12_8_codec
  import hmc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,   // data_byte, received_codeword
  input  wire logic                s_axis_tuser,   // action
  // result stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,   // codeword_out, decoded_byte, syndrome
  output logic [OutUserW-1:0]      m_axis_tuser    // was_corrected, is_valid
);

  // stage one: captured beat
  logic             in_vld_q;
  action_e          act_q;
  logic [ByteW-1:0] byte_q;
  logic [CwW-1:0]   rcw_q;

  // stage two: finished result
  logic             out_vld_q;
  result_t          res_q;
  result_t          res_d;

  logic out_ready;
  logic in_ready;

  // a stage may load when empty or when its content leaves this cycle
  assign out_ready     = !out_vld_q || m_axis_tready;
  assign in_ready      = !in_vld_q || out_ready;
  assign s_axis_tready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      act_q  <= action_e'(s_axis_tuser);
      byte_q <= s_axis_tdata[ByteW-1:0];
      rcw_q  <= s_axis_tdata[ByteW +: CwW];
    end
  end

  // encode and decode paths, both pure xor trees on the stage one register
  logic [CwW-1:0]   enc_data;
  logic [SynW-1:0]  enc_par;
  logic [CwW-1:0]   enc_cw;

  logic [SynW-1:0]  dec_syn;
  logic             dec_fix;
  logic [CwW-1:0]   dec_flip;
  logic [CwW-1:0]   dec_cw;
  logic [ByteW-1:0] dec_byte;

  always_comb begin
    // parity positions are still zero here, so the syndrome is the check bits
    enc_data  = place_byte(byte_q);
    enc_par   = syndrome_of(enc_data);
    enc_cw    = enc_data;
    enc_cw[1] = enc_par[0];
    enc_cw[2] = enc_par[1];
    enc_cw[4] = enc_par[2];
    enc_cw[8] = enc_par[3];
    enc_cw[0] = ^byte_q;

    // syndromes 13..15 name no position and leave the word untouched
    dec_syn  = syndrome_of(rcw_q);
    dec_fix  = (dec_syn != '0) && (dec_syn <= SynW'(CwPosns));
    dec_flip = dec_fix ? (CwW'(1) << dec_syn) : '0;
    dec_cw   = rcw_q ^ dec_flip;
    dec_byte = extract_byte(dec_cw);

    unique case (act_q)
      ACT_ENCODE: begin
        res_d.codeword_out  = enc_cw;
        res_d.decoded_byte  = byte_q;
        res_d.syndrome      = '0;
        res_d.was_corrected = 1'b0;
        res_d.is_valid      = 1'b1;
      end
      ACT_DECODE: begin
        res_d.codeword_out  = dec_cw;
        res_d.decoded_byte  = dec_byte;
        res_d.syndrome      = dec_syn;
        res_d.was_corrected = dec_fix;
        // extra data parity only judged after a correction
        res_d.is_valid      = !dec_fix || ((^dec_byte) == dec_cw[0]);
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_ready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {
    (OutDataW - CwW - ByteW - SynW)'(0),
    res_q.syndrome,
    res_q.decoded_byte,
    res_q.codeword_out
  };
  assign m_axis_tuser  = {res_q.is_valid, res_q.was_corrected};

endmodule

`default_nettype wire

[design/hmc_checker.sv]
// port-level checker for the hamming 12/8 codec, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "hamming_12_8_codec_defines.svh"

module hmc_checker
  import hmc_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata,
  input wire logic [OutUserW-1:0] m_axis_tuser
);

  logic [CwW-1:0]   cw_o;
  logic [ByteW-1:0] byte_o;
  logic [SynW-1:0]  syn_o;
  logic             fix_o;
  logic             ok_o;

  assign cw_o      = m_axis_tdata[CwW-1:0];
  assign byte_o    = m_axis_tdata[CwW +: ByteW];
  assign syn_o     = m_axis_tdata[CwW+ByteW +: SynW];
  assign fix_o     = m_axis_tuser[0];
  assign ok_o      = m_axis_tuser[1];

  // a stalled beat is held
  `HMC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed under stall")

  // every emitted word that names a real position or none is a clean codeword
  `HMC_ASSERT_NOW(a_clean_cw, clk_i, rst_ni, m_axis_tvalid && (syn_o <= SynW'(CwPosns)),
    syndrome_of(cw_o) == '0, "result codeword has nonzero syndrome")

  // the byte always matches the data positions of the codeword
  `HMC_ASSERT_NOW(a_byte_match, clk_i, rst_ni, m_axis_tvalid,
    byte_o == extract_byte(cw_o), "decoded byte disagrees with codeword")

  // a correction needs an in-range nonzero syndrome
  `HMC_ASSERT_NOW(a_fix_range, clk_i, rst_ni, m_axis_tvalid && fix_o,
    (syn_o != '0) && (syn_o <= SynW'(CwPosns)), "correction flagged without a position")

  // only a correction can be judged invalid
  `HMC_ASSERT_NOW(a_valid_flag, clk_i, rst_ni, m_axis_tvalid && !fix_o,
    ok_o, "invalid flag without correction")

endmodule

bind hamming_12_8_codec hmc_checker u_hmc_checker (.*);

`default_nettype wire
